/* hw/rtl/alm_pkg.sv */
// Shared constants and codes for the audio level meter.
`timescale 1ns / 1ps

package alm_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_ATTACK  = 2'd0,
		CFG_RELEASE = 2'd1,
		CFG_BARS    = 2'd2
	} cfg_idx_t;

	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned COEF_W      = 9;
	localparam int unsigned BARS_W      = 7;
	localparam int unsigned PCT_W       = 7;
	localparam int unsigned PEAK_W      = 15;
	localparam int unsigned LEVEL_W     = 15;

	localparam logic [COEF_W-1:0]  ATTACK_RST  = 9'd19;
	localparam logic [COEF_W-1:0]  RELEASE_RST = 9'd5;
	localparam logic [BARS_W-1:0]  BARS_RST    = 7'd8;

	localparam logic [COEF_W-1:0]  COEF_MAX    = 9'd256;
	localparam logic [BARS_W-1:0]  BARS_MAX    = 7'd64;
	localparam logic [PEAK_W-1:0]  PEAK_MAX    = 15'd32767;
	localparam logic [PCT_W-1:0]   PCT_FULL    = 7'd100;
	localparam logic [LEVEL_W-1:0] FULL_Q8     = 15'd25600;

	// Rounding offset for peak*100 / 32767
	localparam logic [14:0]        PCT_ROUND   = 15'd16383;
	// Rounding offset and reciprocal for the divide by 100 in the bar count
	localparam logic [12:0]        BAR_ROUND   = 13'd50;
	localparam logic [13:0]        RECIP_100   = 14'd5243;
	localparam int unsigned        RECIP_SHIFT = 19;

endpackage

/* hw/rtl/audio_level_meter_attack_release_top.sv */
// Audio level meter: frame peak tracker with attack/release level smoothing.
`timescale 1ns / 1ps
// Samples without frame end may follow back to back; a frame-end sample stalls the input.
// A frame-end sample runs through one shared 17x14 multiplier under a small sequencer:
//   percent, divide, then scale and update on later frames only, two bar steps and output;
// the output step waits out any output stall, then registers the result.
// Reset (arst_n low, asynchronous): peak, level and primed flag clear, registers take
//   attack 19, release 5, bar count 8, no result pending.

module audio_level_meter_attack_release_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// sample channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [15:0]               sample,
	input  logic                             frame_end,
	// result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [alm_pkg::PCT_W-1:0]        level_pct,
	output logic [alm_pkg::BARS_W-1:0]       bars_lit,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [alm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [alm_pkg::COEF_W-1:0]       cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PCT,
		ST_DIV,
		ST_SCALE,
		ST_UPD,
		ST_BAR1,
		ST_BAR2,
		ST_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [alm_pkg::COEF_W-1:0]  attack_q;
	logic [alm_pkg::COEF_W-1:0]  release_q;
	logic [alm_pkg::BARS_W-1:0]  bars_max_q;

	// running state
	logic [alm_pkg::PEAK_W-1:0]  frame_peak_q;
	logic [alm_pkg::LEVEL_W-1:0] level_q;
	logic                        primed_q;

	// work registers of the sequencer
	logic [alm_pkg::PEAK_W-1:0]  peak_q;
	logic [alm_pkg::LEVEL_W-1:0] tq8_q;
	logic [alm_pkg::PCT_W-1:0]   pct_q;
	logic signed [30:0]          acc_q;

	// output register
	logic                        out_valid_q;
	logic [alm_pkg::PCT_W-1:0]   level_pct_q;
	logic [alm_pkg::BARS_W-1:0]  bars_lit_q;

	// ---------------------------------------------------------------
	// Sample magnitude, saturated so that -32768 maps to 32767
	// ---------------------------------------------------------------
	logic [15:0]                 mag16;
	logic [alm_pkg::PEAK_W-1:0]  mag;
	logic [alm_pkg::PEAK_W-1:0]  peak_next;

	assign mag16     = sample[15] ? (~sample + 16'd1) : sample;
	assign mag       = mag16[15] ? alm_pkg::PEAK_MAX : mag16[14:0];
	assign peak_next = (mag > frame_peak_q) ? mag : frame_peak_q;

	// ---------------------------------------------------------------
	// Saturated coefficients
	// ---------------------------------------------------------------
	logic [alm_pkg::COEF_W-1:0]  attack_sat;
	logic [alm_pkg::COEF_W-1:0]  release_sat;
	logic [alm_pkg::BARS_W-1:0]  bars_max_sat;
	logic [alm_pkg::COEF_W-1:0]  coef_sel;

	assign attack_sat   = (attack_q > alm_pkg::COEF_MAX) ? alm_pkg::COEF_MAX : attack_q;
	assign release_sat  = (release_q > alm_pkg::COEF_MAX) ? alm_pkg::COEF_MAX : release_q;
	assign bars_max_sat = (bars_max_q > alm_pkg::BARS_MAX) ? alm_pkg::BARS_MAX : bars_max_q;
	// rising or equal target uses the attack coefficient
	assign coef_sel     = (tq8_q >= level_q) ? attack_sat : release_sat;

	// ---------------------------------------------------------------
	// Shared multiplier: operands picked by the sequencer state
	// ---------------------------------------------------------------
	logic signed [16:0] diff;
	logic [12:0]        bar_sum;
	logic signed [16:0] mul_a;
	logic signed [13:0] mul_b;
	logic signed [30:0] mul_p;

	assign diff    = $signed({2'b00, tq8_q}) - $signed({2'b00, level_q});
	assign bar_sum = acc_q[12:0] + alm_pkg::BAR_ROUND;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_PCT: begin
				// peak * 100
				mul_a = $signed({2'b00, peak_q});
				mul_b = $signed({7'd0, alm_pkg::PCT_FULL});
			end
			ST_SCALE: begin
				// (target - level) * coefficient
				mul_a = diff;
				mul_b = $signed({5'd0, coef_sel});
			end
			ST_BAR1: begin
				// pct * bar count
				mul_a = $signed({10'd0, pct_q});
				mul_b = $signed({7'd0, bars_max_sat});
			end
			ST_BAR2: begin
				// (pct * bars + 50) / 100 through the reciprocal
				mul_a = $signed({4'd0, bar_sum});
				mul_b = $signed(alm_pkg::RECIP_100);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// ---------------------------------------------------------------
	// Divide by 32767 = 2^15 - 1: take x >> 15, then one correction step
	// ---------------------------------------------------------------
	logic [21:0]               div_x;
	logic [6:0]                div_q0;
	logic [15:0]               div_r;
	logic [alm_pkg::PCT_W-1:0] tpct;
	logic [alm_pkg::LEVEL_W-1:0] tq8;

	assign div_x  = acc_q[21:0];
	assign div_q0 = div_x[21:15];
	assign div_r  = {1'b0, div_x[14:0]} + {9'd0, div_q0};
	assign tpct   = (div_r >= {1'b0, alm_pkg::PEAK_MAX}) ? (div_q0 + 7'd1) : div_q0;
	assign tq8    = (tpct > alm_pkg::PCT_FULL) ? alm_pkg::FULL_Q8 : {tpct, 8'd0};

	// ---------------------------------------------------------------
	// Level step: product / 256 truncated toward zero
	// ---------------------------------------------------------------
	logic signed [30:0] acc_adj;
	logic signed [30:0] step_full;
	logic signed [16:0] lvl_sum;
	logic [alm_pkg::PCT_W-1:0] lvl_pct;

	assign acc_adj   = acc_q[30] ? (acc_q + 31'sd255) : acc_q;
	assign step_full = acc_adj >>> 8;
	assign lvl_sum   = $signed({2'b00, level_q}) + step_full[16:0];
	assign lvl_pct   = (lvl_sum[14:8] > alm_pkg::PCT_FULL) ? alm_pkg::PCT_FULL : lvl_sum[14:8];

	// ---------------------------------------------------------------
	// Bar count from the reciprocal product, with the special cases
	// ---------------------------------------------------------------
	logic [alm_pkg::BARS_W-1:0] bars_q_div;
	logic [alm_pkg::BARS_W-1:0] bars;

	assign bars_q_div = acc_q[alm_pkg::RECIP_SHIFT +: alm_pkg::BARS_W];

	always_comb begin
		if (bars_max_sat == '0 || pct_q == '0) begin
			bars = '0;
		end else if (pct_q >= alm_pkg::PCT_FULL) begin
			bars = bars_max_sat;
		end else begin
			bars = bars_q_div;
		end
	end

	// ---------------------------------------------------------------
	// Handshakes
	// ---------------------------------------------------------------
	logic in_xfer;
	logic out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	// write registers only while the block is idle (unenforced); always take the transfer
	assign cfg_ready = 1'b1;

	assign out_valid = out_valid_q;
	assign level_pct = level_pct_q;
	assign bars_lit  = bars_lit_q;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q   <= alm_pkg::ATTACK_RST;
			release_q  <= alm_pkg::RELEASE_RST;
			bars_max_q <= alm_pkg::BARS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				alm_pkg::CFG_ATTACK:  attack_q   <= cfg_data;
				alm_pkg::CFG_RELEASE: release_q  <= cfg_data;
				alm_pkg::CFG_BARS:    bars_max_q <= cfg_data[alm_pkg::BARS_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Sequencer, running state and output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			frame_peak_q <= '0;
			level_q      <= '0;
			primed_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// drop the result once the sink takes it, unless a new one loads now
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (frame_end) begin
							// hand the frame peak to the sequencer, start the next frame
							peak_q       <= peak_next;
							frame_peak_q <= '0;
							state_q      <= ST_PCT;
						end else begin
							frame_peak_q <= peak_next;
						end
					end
				end
				ST_PCT: begin
					acc_q   <= mul_p + $signed({16'd0, alm_pkg::PCT_ROUND});
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					tq8_q  <= tq8;
					if (!primed_q) begin
						// first frame loads the target directly
						level_q  <= tq8;
						pct_q    <= (tpct > alm_pkg::PCT_FULL) ? alm_pkg::PCT_FULL : tpct;
						primed_q <= 1'b1;
						state_q  <= ST_BAR1;
					end else begin
						state_q  <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					acc_q   <= mul_p;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					level_q <= lvl_sum[alm_pkg::LEVEL_W-1:0];
					pct_q   <= lvl_pct;
					state_q <= ST_BAR1;
				end
				ST_BAR1: begin
					acc_q   <= mul_p;
					state_q <= ST_BAR2;
				end
				ST_BAR2: begin
					acc_q   <= mul_p;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						level_pct_q <= pct_q;
						bars_lit_q  <= bars;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/alm_checker.sv */
// Port-level checker for the audio level meter, bound to the top level.
`timescale 1ns / 1ps

module alm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          frame_end,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [alm_pkg::PCT_W-1:0]     level_pct,
	input logic [alm_pkg::BARS_W-1:0]    bars_lit
);

	// a frame end starts the level update, so the next sample waits
	a_frame_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && frame_end |=> in_stall)
		else $error("frame end did not start the level update");

	// a plain sample does not stall the input
	a_sample_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !frame_end |=> !in_stall)
		else $error("plain sample stalled the input");

	// a new result only appears at the end of an update
	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a level update");

	// results stay in range
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (level_pct <= alm_pkg::PCT_FULL) && (bars_lit <= alm_pkg::BARS_MAX))
		else $error("result out of range");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(level_pct) && $stable(bars_lit))
		else $error("stalled result changed");

endmodule

bind audio_level_meter_attack_release_top alm_checker u_alm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.frame_end (frame_end),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.level_pct (level_pct),
	.bars_lit  (bars_lit)
);

/* tb/sv/tb_audio_level_meter_attack_release_top.sv */
// Self-checking testbench for the audio level meter with attack/release smoothing.
`timescale 1ns / 1ps

// Samples go in through a queue-fed driver, and readings are checked as they come out.
// The monitor keeps a copy of the meter state: the running frame peak,
// the Q8 level and the primed flag. On every sample transfer it updates that copy. On a
// frame end it also predicts the reading (level percent and bar count) and stores it in
// order. Every reading transfer is compared with the oldest stored reading.
//
// Run outline:
//   - reset, then a short directed set under the reset coefficients: first-frame direct
//     load, the most negative sample, full scale, silence, the peak held across a frame,
//     and rounding edges of the percent conversion
//   - several random phases, each with its own register setting and idling mix:
//     coefficients at zero, 256 and above 256, bar counts of zero, 64 and above 64
//   - one phase where the receiver holds off for a long stretch while samples keep
//     coming, so the meter backs up into its input
//   - one phase where the sender stops and waits until every reading has come out
// Registers are only written once the meter is drained and has had its tail cycles.

module tb_audio_level_meter_attack_release_top;

	localparam int CLK_HALF    = 5;
	localparam int RST_CYCLES  = 9;
	localparam int TAIL_CYCLES = 16;     // covers frame-end work still in flight, plus margin
	localparam int HOLD_CYCLES = 400;    // long receiver hold-off in the pressure phase
	localparam int CYCLE_LIMIT = 400000;
	localparam int Q8_ONE      = 256;
	localparam int MAX_SHOWN   = 10;

	typedef struct {
		logic signed [15:0] smp;
		logic               fe;
	} audio_item_t;

	typedef struct {
		logic [alm_pkg::PCT_W-1:0]  pct;
		logic [alm_pkg::BARS_W-1:0] bars;
	} meter_reading_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            in_valid  = 1'b0;
	logic                            in_stall;
	logic signed [15:0]              sample    = '0;
	logic                            frame_end = 1'b0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [alm_pkg::PCT_W-1:0]       level_pct;
	logic [alm_pkg::BARS_W-1:0]      bars_lit;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [alm_pkg::CFG_IDX_W-1:0]   cfg_index = alm_pkg::CFG_ATTACK;
	logic [alm_pkg::COEF_W-1:0]      cfg_data  = '0;

	// Stimulus and scoreboard
	audio_item_t    pending_samples_q[$];
	meter_reading_t level_readings_q[$];
	logic           in_taken = 1'b0;
	int             n_pushed = 0;
	int             n_accepted = 0;
	int             n_readings = 0;
	int             n_errors = 0;
	int             n_reg_writes = 0;
	int             n_phases = 0;
	int             cycle_count = 0;

	// Idling controls; the percentages and hold_toggle are written by the sequence only
	int             tx_idle_pct = 0;
	int             rx_stall_pct = 0;
	logic           hold_toggle = 1'b0;
	logic           hold_ack = 1'b0;
	int             hold_left = 0;

	// Predicted meter state and register copies
	int             peak_run = 0;
	int             level_q8 = 0;
	logic           primed = 1'b0;
	int             attack_set = int'(alm_pkg::ATTACK_RST);
	int             release_set = int'(alm_pkg::RELEASE_RST);
	int             bars_set = int'(alm_pkg::BARS_RST);

	audio_level_meter_attack_release_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.frame_end (frame_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.level_pct (level_pct),
		.bars_lit  (bars_lit),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Bound the run; a hang anywhere ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d of %0d samples taken, %0d readings open",
				cycle_count, n_accepted, n_pushed, level_readings_q.size());
			$display("tb: failure");
			$finish;
		end
	end

	// Track one sample transfer: fold it into the frame peak, and on a frame end move the
	// level toward the new target and store the reading it produces.
	task automatic follow_envelope(input logic signed [15:0] smp, input logic fe);
		int mag;
		int goal_pct;
		int goal_lvl;
		int coef;
		int pct;
		int bar_cap;
		int bar_n;
		meter_reading_t rd;
		mag = (smp < 0) ? -int'(smp) : int'(smp);
		if (mag > int'(alm_pkg::PEAK_MAX))
			mag = int'(alm_pkg::PEAK_MAX);   // the most negative sample clips to full scale
		if (mag > peak_run)
			peak_run = mag;
		if (fe) begin
			goal_pct = (peak_run * int'(alm_pkg::PCT_FULL) + int'(alm_pkg::PCT_ROUND))
				/ int'(alm_pkg::PEAK_MAX);
			goal_lvl = goal_pct * Q8_ONE;
			if (goal_lvl > int'(alm_pkg::FULL_Q8))
				goal_lvl = int'(alm_pkg::FULL_Q8);
			if (!primed) begin
				// first frame after reset: jump straight to the target
				level_q8 = goal_lvl;
				primed = 1'b1;
				pct = goal_pct;
			end else begin
				coef = (goal_lvl >= level_q8) ? attack_set : release_set;
				if (coef > int'(alm_pkg::COEF_MAX))
					coef = int'(alm_pkg::COEF_MAX);
				// signed divide truncates toward zero on both rising and falling steps
				level_q8 = level_q8 + ((goal_lvl - level_q8) * coef) / Q8_ONE;
				pct = level_q8 / Q8_ONE;
			end
			if (pct > int'(alm_pkg::PCT_FULL))
				pct = int'(alm_pkg::PCT_FULL);
			bar_cap = (bars_set > int'(alm_pkg::BARS_MAX)) ? int'(alm_pkg::BARS_MAX) : bars_set;
			rd.pct = pct[alm_pkg::PCT_W-1:0];
			if (bar_cap == 0 || pct == 0) begin
				rd.bars = '0;
			end else if (pct >= int'(alm_pkg::PCT_FULL)) begin
				rd.bars = bar_cap[alm_pkg::BARS_W-1:0];
			end else begin
				bar_n = (pct * bar_cap + int'(alm_pkg::BAR_ROUND)) / int'(alm_pkg::PCT_FULL);
				rd.bars = bar_n[alm_pkg::BARS_W-1:0];
			end
			level_readings_q.push_back(rd);
			peak_run = 0;
		end
	endtask

	// Monitor: sample both channels at the rising edge. Check the reading before the
	// new sample is folded in, so that a stray output cannot match a prediction made
	// in the same cycle.
	always @(posedge clk) begin : watch_channels
		meter_reading_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (level_readings_q.size() == 0) begin
					n_errors++;
					if (n_errors <= MAX_SHOWN)
						$display("%0t: reading with none expected: pct %0d bars %0d",
							$realtime, level_pct, bars_lit);
				end else begin
					want = level_readings_q.pop_front();
					n_readings++;
					if (level_pct !== want.pct || bars_lit !== want.bars) begin
						n_errors++;
						if (n_errors <= MAX_SHOWN)
							$display("%0t: reading %0d: pct exp %0d got %0d, bars exp %0d got %0d",
								$realtime, n_readings, want.pct, level_pct, want.bars, bars_lit);
					end
				end
			end
			if (in_valid && !in_stall) begin
				follow_envelope(sample, frame_end);
				n_accepted++;
			end
			in_taken <= in_valid && !in_stall;
		end
	end

	// Sample driver: hold a stalled sample, otherwise present the next queued one unless
	// this cycle is picked as an idle cycle.
	always @(negedge clk) begin : drive_samples
		audio_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			// hold the payload until the transfer happens
		end else if (pending_samples_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
			nxt = pending_samples_q.pop_front();
			in_valid <= 1'b1;
			sample <= nxt.smp;
			frame_end <= nxt.fe;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Reading receiver: a long hold-off when requested, otherwise random stalls.
	always @(negedge clk) begin : drive_result_stall
		if (hold_toggle != hold_ack) begin
			hold_ack <= hold_toggle;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	task automatic push_sample(input logic signed [15:0] smp, input logic fe);
		audio_item_t it;
		it.smp = smp;
		it.fe = fe;
		pending_samples_q.push_back(it);
		n_pushed++;
	endtask

	// Queue random frames until at least n_items samples are added. Short frames keep
	// the level math busy on nearly every sample.
	task automatic queue_frames(input int n_items, input logic short_frames);
		int added;
		int len;
		int amp;
		logic signed [15:0] smp;
		added = 0;
		while (added < n_items) begin
			if (short_frames)
				len = $urandom_range(2, 1);
			else if ($urandom_range(7) == 0)
				len = $urandom_range(40, 13);
			else
				len = $urandom_range(8, 1);
			amp = $urandom_range(32767);
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(5))
					0: smp = 16'($urandom);
					1: smp = 16'($urandom_range(600) - 300);
					2: begin
						case ($urandom_range(3))
							0: smp = 16'sh8000;
							1: smp = 16'sh7fff;
							2: smp = 16'sh8001;
							default: smp = 16'sh0000;
						endcase
					end
					3: smp = '0;
					default: smp = 16'($urandom_range(2 * amp) - amp);
				endcase
				push_sample(smp, i == len - 1);
			end
			added += len;
		end
	endtask

	// Wait until every queued sample is taken and every reading has come out, then let
	// the meter finish any frame-end work still in flight.
	task automatic wait_meter_idle();
		while (n_accepted != n_pushed || level_readings_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input alm_pkg::cfg_idx_t idx, input int unsigned value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[alm_pkg::COEF_W-1:0];
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			alm_pkg::CFG_ATTACK:  attack_set = int'(value[alm_pkg::COEF_W-1:0]);
			alm_pkg::CFG_RELEASE: release_set = int'(value[alm_pkg::COEF_W-1:0]);
			alm_pkg::CFG_BARS:    bars_set = int'(value[alm_pkg::BARS_W-1:0]);
			default: ;
		endcase
		n_reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// One random phase: set the registers while idle, pick the idling mix, queue frames,
	// then drain. mid_pause stops the sender halfway until all readings are in;
	// long_hold makes the receiver sit out a long stretch while samples keep flowing.
	task automatic run_phase(input int unsigned atk, input int unsigned rel,
			input int unsigned bars, input int tx_pct, input int rx_pct,
			input int n_items, input logic mid_pause, input logic long_hold);
		write_reg(alm_pkg::CFG_ATTACK, atk);
		write_reg(alm_pkg::CFG_RELEASE, rel);
		write_reg(alm_pkg::CFG_BARS, bars);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		n_phases++;
		if (mid_pause) begin
			queue_frames(n_items / 2, 1'b0);
			wait_meter_idle();
			queue_frames(n_items / 2, 1'b0);
		end else begin
			queue_frames(n_items, long_hold);
			if (long_hold)
				hold_toggle = ~hold_toggle;
		end
		wait_meter_idle();
	endtask

	initial begin
		repeat (RST_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset coefficients.
		push_sample(16'sh8000, 1'b1);   // first frame loads directly; clipped magnitude
		push_sample(16'sh0000, 1'b1);   // fall to silence through the release path
		push_sample(16'sh7fff, 1'b0);   // peak must survive to the frame end
		push_sample(16'sh0000, 1'b1);
		push_sample(16'sh0001, 1'b0);
		push_sample(16'shffff, 1'b0);
		push_sample(16'sh0010, 1'b1);
		push_sample(16'sh0000, 1'b1);
		push_sample(16'sh8001, 1'b1);   // full scale, rising through attack
		push_sample(16'sh3fff, 1'b1);   // around the 50 percent rounding edge
		push_sample(16'sh4000, 1'b1);
		push_sample(16'sh00a3, 1'b1);   // just under and over half a percent
		push_sample(16'sh00a4, 1'b1);
		push_sample(16'shc000, 1'b0);
		push_sample(16'sh1f40, 1'b1);
		push_sample(16'sh7fff, 1'b1);   // rising target, on the attack path
		push_sample(16'sh7fff, 1'b1);
		wait_meter_idle();

		// Random phases, extremes of every register among them.
		run_phase(256, 256, 64, 0, 0, 110, 1'b0, 1'b0);
		run_phase(0, 0, 0, 58, 0, 110, 1'b0, 1'b0);
		run_phase(511, 300, 127, 0, 58, 110, 1'b0, 1'b0);
		run_phase($urandom_range(511), $urandom_range(511), $urandom_range(127),
			24, 24, 110, 1'b1, 1'b0);
		run_phase(1, 1, 1, 0, 0, 110, 1'b0, 1'b1);
		run_phase(128, 40, 10, 24, 24, 110, 1'b0, 1'b0);
		run_phase($urandom_range(300), $urandom_range(300), $urandom_range(80),
			58, 58, 110, 1'b0, 1'b0);

		n_errors += level_readings_q.size();
		$display("Ran %0d samples through %0d register settings (%0d writes); %0d readings checked",
			n_accepted, n_phases + 1, n_reg_writes, n_readings);
		$display("Mismatches and unexpected or missing readings: %0d", n_errors);
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
